// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, request and status codes, and the memory command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned PosW         = 8;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned LenW         = 9;
  localparam int unsigned DepthDefault = 256;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_READ_FRONT = 3'd6,
    MODE_READ_BACK  = 3'd7
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/deq_in_if.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_in_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ModeW-1:0]         mode;
  logic signed [DataW-1:0]  value;
  logic [PosW-1:0]          position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_out_if.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue reply channel
// Valid/ready channel carrying one reply word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface deq_out_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DataW-1:0]  data;
  logic [StatusW-1:0]       status;
  logic [LenW-1:0]          length;

  modport source (output valid, data, status, length, input ready);
  modport sink   (input valid, data, status, length, output ready);
endinterface

`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue pointer control
// Holds head and occupancy, decodes a request into a slot access and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl #(
  parameter  int unsigned Depth = deq_pkg::DepthDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  deq_pkg::mode_e             mode_i,
  input  logic [deq_pkg::PosW-1:0]   position_i,
  output deq_pkg::mem_cmd_t          cmd_o,
  output logic [AddrW-1:0]           addr_o,
  output deq_pkg::status_e           status_o,
  output logic [deq_pkg::LenW-1:0]   length_o
);
  import deq_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0]  DepthC = CntW'(Depth);
  localparam logic [AddrW:0]   DepthA = (AddrW + 1)'(Depth);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);

  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  occ_q, occ_d;
  logic [CntW-1:0]  offset;
  logic [AddrW:0]   sum;
  logic [AddrW-1:0] slot;
  logic             full, empty, in_range, acc;
  mem_cmd_t         cmd;
  status_e          status;

  assign full     = (occ_q == DepthC);
  assign empty    = (occ_q == '0);
  assign in_range = (CmpW'(position_i) < CmpW'(occ_q));

  // Distance from the front of the element this request touches.
  always_comb begin
    case (mode_i) inside
      MODE_PUSH_BACK:                 offset = occ_q;
      MODE_POP_BACK, MODE_PEEK_BACK:  offset = occ_q - 1'b1;
      MODE_READ_FRONT:                offset = CntW'(position_i);
      MODE_READ_BACK:                 offset = occ_q - 1'b1 - CntW'(position_i);
      default:                        offset = '0;
    endcase
  end

  // Head plus distance stays below twice the depth, so one subtract wraps it.
  assign sum  = (AddrW + 1)'(head_q) + (AddrW + 1)'(AddrW'(offset));
  assign slot = (sum >= DepthA) ? AddrW'(sum - DepthA) : AddrW'(sum);

  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    cmd    = '0;
    addr_o = slot;
    status = ST_OK;
    unique case (mode_i) inside
      MODE_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          head_d     = (head_q == '0) ? LastIdx : head_q - 1'b1;
          addr_o     = head_d;
          cmd.wr_en  = 1'b1;
          occ_d      = occ_q + 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.wr_en = 1'b1;
          occ_d     = occ_q + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.rd_en = 1'b1;
          if (mode_i == MODE_POP_FRONT) begin
            head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
            occ_d  = occ_q - 1'b1;
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.rd_en = 1'b1;
          if (mode_i == MODE_POP_BACK) begin
            occ_d = occ_q - 1'b1;
          end
        end
      end
      MODE_READ_FRONT, MODE_READ_BACK: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign acc      = accept_i;
  assign cmd_o    = acc ? cmd : '0;
  assign status_o = status;
  assign length_o = LenW'(occ_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
    end else if (acc) begin
      head_q <= head_d;
      occ_q  <= occ_d;
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DepthC) else $error("occupancy above depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastIdx) else $error("head index outside the buffer");

  a_full_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && full && (mode_i == MODE_PUSH_FRONT || mode_i == MODE_PUSH_BACK)
    |=> $stable(occ_q) && $stable(head_q))
    else $error("refused push changed the pointers");

endmodule

`default_nettype wire

// ===== rtl/deq_mem.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue slot memory
// Single-port word store with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_mem #(
  parameter  int unsigned Depth = deq_pkg::DepthDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                               clk_i,
  input  deq_pkg::mem_cmd_t                  cmd_i,
  input  logic [AddrW-1:0]                   addr_i,
  input  logic signed [deq_pkg::DataW-1:0]   wdata_i,
  output logic signed [deq_pkg::DataW-1:0]   rdata_o
);
  import deq_pkg::*;

  logic signed [DataW-1:0] mem [Depth];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit words held in a ring buffer.
// ----------------------------------------------------------------------------
// The core takes one request word per cycle and answers each with exactly one
// reply word, in the cycle after the request is accepted, as long as the reply
// side keeps taking words. The request is decoded against the head pointer
// and the occupancy count in the same cycle it is accepted; at that clock
// edge the pointers update and the single slot that the request touches is
// written or read through the one port of the slot memory. The reply's data
// comes straight out of that memory's read register, and status and length
// are registered next to it. When the reply waits, the core holds off new
// requests, since the memory read register is the reply's data holder.
// The slot memory is not cleared after reset and needs no clearing pass:
// only slots that were pushed are ever read. Pushes and errors reply with
// data 0; the length field reports the occupancy after the request.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
  parameter int unsigned DEPTH = deq_pkg::DepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  deq_in_if.sink   in_i,
  deq_out_if.source out_o
);
  import deq_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                    accept;
  mem_cmd_t                cmd;
  logic [AddrW-1:0]        addr;
  status_e                 status_d, status_q;
  logic [LenW-1:0]         length_d, length_q;
  logic                    zero_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] rdata;

  // A new request enters whenever the reply register is empty or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  deq_ctrl #(
    .Depth (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .mode_i     (mode_e'(in_i.mode)),
    .position_i (in_i.position),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .status_o   (status_d),
    .length_o   (length_d)
  );

  deq_mem #(
    .Depth (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .addr_i  (addr),
    .wdata_i (in_i.value),
    .rdata_o (rdata)
  );

  // Reply register: status, length and a flag that forces the data to zero
  // when no slot was read for this request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      length_q <= length_d;
      zero_q   <= !cmd.rd_en;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.data   = zero_q ? '0 : rdata;
  assign out_o.status = status_q;
  assign out_o.length = length_q;

  a_accept_gives_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q) else $error("accepted request produced no reply");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> zero_q)
    else $error("error reply carries nonzero data");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !accept)
    else $error("request accepted over a waiting reply");

endmodule

`default_nettype wire

// ===== bench/double_ended_queue_checker.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue reply checker
// Watches the request and reply channels of the deque core. It keeps its own
// copy of the ring buffer, predicts the reply to every accepted request and
// compares each accepted reply with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_checker
  import deq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  logic                    req_ready_i,
  input  logic [ModeW-1:0]        req_mode_i,
  input  logic signed [DataW-1:0] req_value_i,
  input  logic [PosW-1:0]         req_position_i,
  input  logic                    rsp_valid_i,
  input  logic                    rsp_ready_i,
  input  logic signed [DataW-1:0] rsp_data_i,
  input  logic [StatusW-1:0]      rsp_status_i,
  input  logic [LenW-1:0]         rsp_length_i,
  output int unsigned             error_count_o,
  output int unsigned             pending_o
);

  localparam int unsigned Depth = DepthDefault;

  typedef struct {
    logic signed [DataW-1:0] data;
    status_e                 status;
    logic [LenW-1:0]         length;
  } reply_t;

  logic [DataW-1:0] slot_mem [Depth];
  int unsigned      head_ptr;
  int unsigned      fill_level;
  reply_t           reply_q [$];

  // Applies one request to the shadow deque and returns the reply it causes.
  function automatic reply_t apply_request(mode_e op, logic [DataW-1:0] word,
                                           logic [PosW-1:0] pos);
    reply_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (op) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (fill_level >= Depth) begin
          r.status = ST_FULL;
        end else if (op == MODE_PUSH_FRONT) begin
          head_ptr = (head_ptr + Depth - 1) % Depth;
          slot_mem[head_ptr] = word;
          fill_level++;
        end else begin
          slot_mem[(head_ptr + fill_level) % Depth] = word;
          fill_level++;
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = slot_mem[head_ptr];
          if (op == MODE_POP_FRONT) begin
            head_ptr = (head_ptr + 1) % Depth;
            fill_level--;
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = slot_mem[(head_ptr + fill_level - 1) % Depth];
          if (op == MODE_POP_BACK) fill_level--;
        end
      end
      default: begin
        if (pos >= fill_level) begin
          r.status = ST_RANGE;
        end else if (op == MODE_READ_FRONT) begin
          r.data = slot_mem[(head_ptr + pos) % Depth];
        end else begin
          r.data = slot_mem[(head_ptr + fill_level - 1 - pos) % Depth];
        end
      end
    endcase
    r.length = LenW'(fill_level);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      head_ptr      = 0;
      fill_level    = 0;
      error_count_o = 0;
      reply_q.delete();
    end else begin
      // A reply is never caused by a request taken at the same edge, so
      // replies are matched before the new request is predicted.
      if (rsp_valid_i && rsp_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: reply with none expected: data %0d status %0d length %0d",
                   $time, rsp_data_i, rsp_status_i, rsp_length_i);
          error_count_o++;
        end else begin
          want = reply_q.pop_front();
          if (rsp_data_i !== want.data || rsp_status_i !== want.status ||
              rsp_length_i !== want.length) begin
            $display("%0t: expected data %0d status %0d length %0d, got %0d %0d %0d",
                     $time, want.data, want.status, want.length,
                     rsp_data_i, rsp_status_i, rsp_length_i);
            error_count_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        reply_q.push_back(apply_request(mode_e'(req_mode_i), req_value_i,
                                        req_position_i));
      end
    end
    pending_o = reply_q.size();
  end

endmodule

// ===== bench/double_ended_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives directed and random requests into the deque core with random idle
// bursts on both channels, and lets a checker predict and compare replies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
  import deq_pkg::*;

  // Generous bound on the whole run, far above the slowest legal run.
  localparam int unsigned CycleLimit = 300000;
  // The core answers in the cycle after it takes a request; the tail covers slack.
  localparam int unsigned TailCycles = 16;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          quiet_mode = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned error_count;
  int unsigned pending_count;

  deq_in_if  req_if ();
  deq_out_if rsp_if ();

  double_ended_queue_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  double_ended_queue_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_if.valid),
    .req_ready_i    (req_if.ready),
    .req_mode_i     (req_if.mode),
    .req_value_i    (req_if.value),
    .req_position_i (req_if.position),
    .rsp_valid_i    (rsp_if.valid),
    .rsp_ready_i    (rsp_if.ready),
    .rsp_data_i     (rsp_if.data),
    .rsp_status_i   (rsp_if.status),
    .rsp_length_i   (rsp_if.length),
    .error_count_o  (error_count),
    .pending_o      (pending_count)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The reply side stalls in random bursts, and never once the quiet part of
  // the run has begun and the current burst is over.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Presents one request word and holds it until the core takes it. An idle
  // burst may come first; valid only drops when such a burst is inserted, so
  // back-to-back words keep valid high across the edge.
  task automatic send_request(mode_e op, logic [DataW-1:0] word,
                              logic [PosW-1:0] pos);
    int unsigned gap;
    @(negedge clk_i);
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= op;
    req_if.value    <= word;
    req_if.position <= pos;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Drops valid and waits until every reply in flight has come back.
  task automatic drain_replies();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // Uniform mix of all requests. Read positions are mostly kept close to
  // the ends, where the stored words are, and sometimes span the whole range.
  task automatic mixed_run(int unsigned n);
    logic [PosW-1:0] pos;
    repeat (n) begin
      pos = ($urandom_range(0, 1) == 0) ? PosW'($urandom_range(0, 15))
                                        : PosW'($urandom_range(0, 255));
      send_request(mode_e'($urandom_range(0, 7)), $urandom, pos);
    end
  endtask

  // Long run of pushes (grow) or pops (shrink) from random ends, with reads
  // and peeks mixed in. Enough steps to reach full or empty from any level,
  // so refused pushes and empty pops are hit on the way.
  task automatic end_run(int unsigned n, bit grow);
    repeat (n) begin
      if (grow) begin
        send_request($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                     $urandom, PosW'($urandom_range(0, 255)));
      end else begin
        send_request($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT,
                     $urandom, PosW'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
        send_request(mode_e'($urandom_range(MODE_PEEK_FRONT, MODE_READ_BACK)),
                     $urandom, PosW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_PUSH_FRONT;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Every pop, peek and read on the empty queue first.
    send_request(MODE_POP_FRONT,  $urandom, 8'd0);
    send_request(MODE_POP_BACK,   $urandom, 8'd0);
    send_request(MODE_PEEK_FRONT, $urandom, 8'd0);
    send_request(MODE_PEEK_BACK,  $urandom, 8'd0);
    send_request(MODE_READ_FRONT, $urandom, 8'd0);
    send_request(MODE_READ_BACK,  $urandom, 8'd255);
    // Extreme words pushed at both ends: front to back -1, min, max, 0.
    send_request(MODE_PUSH_BACK,  32'h7FFF_FFFF, 8'd0);
    send_request(MODE_PUSH_FRONT, 32'h8000_0000, 8'd0);
    send_request(MODE_PUSH_BACK,  32'h0000_0000, 8'd0);
    send_request(MODE_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0);
    send_request(MODE_PEEK_FRONT, $urandom, 8'd0);
    send_request(MODE_PEEK_BACK,  $urandom, 8'd0);
    send_request(MODE_READ_FRONT, $urandom, 8'd1);
    send_request(MODE_READ_BACK,  $urandom, 8'd1);
    send_request(MODE_READ_FRONT, $urandom, 8'd3);
    // Positions at and far beyond the length are out of range.
    send_request(MODE_READ_FRONT, $urandom, 8'd4);
    send_request(MODE_READ_BACK,  $urandom, 8'd255);
    send_request(MODE_POP_FRONT,  $urandom, 8'd0);
    send_request(MODE_POP_BACK,   $urandom, 8'd0);
    send_request(MODE_POP_FRONT,  $urandom, 8'd0);
    send_request(MODE_POP_BACK,   $urandom, 8'd0);
    send_request(MODE_POP_FRONT,  $urandom, 8'd0);
    send_request(MODE_PUSH_FRONT, 32'h5A5A_5A5A, 8'd0);
    send_request(MODE_READ_BACK,  $urandom, 8'd0);
    send_request(MODE_POP_BACK,   $urandom, 8'd0);

    // Random part: mixed requests, fill to full, work around full, drain to empty, then mixed requests again.
    mixed_run(220);
    drain_replies();
    end_run(300, 1'b1);
    mixed_run(150);
    end_run(300, 1'b0);
    drain_replies();
    mixed_run(250);

    // Last stretch runs with no idling on either side.
    quiet_mode = 1'b1;
    mixed_run(260);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (error_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
